// File: rtl/core/i2c_rtm_pkg.sv
`timescale 1ns / 1ps

package i2c_rtm_pkg;

    // Sequence steps of the transfer
    typedef enum logic [3:0] {
        ST_IDLE   = 4'd0,
        ST_START  = 4'd1,
        ST_ADDRW  = 4'd2,
        ST_REG    = 4'd3,
        ST_DATA   = 4'd4,
        ST_RSTART = 4'd5,
        ST_ADDRR  = 4'd6,
        ST_RECV   = 4'd7,
        ST_STOP   = 4'd8
    } t_step;

    // Quarter-bit phases: in bit steps SCL is low in Q0/Q3 and high in Q1/Q2; SDA sampled in Q2
    localparam logic [1:0] Q0 = 2'd0;
    localparam logic [1:0] Q1 = 2'd1;
    localparam logic [1:0] Q2 = 2'd2;
    localparam logic [1:0] Q3 = 2'd3;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [3:0] LAST_BIT      = 4'd7;

    localparam int          CFG_ADDR_W        = 3;
    localparam int          CFG_DATA_W        = 32;
    localparam logic        REG_DEVICE_ADDR   = 1'b0;  // register index, paddr[2]
    localparam logic [6:0]  DEVICE_ADDR_RESET = 7'd104;

    typedef struct packed {
        logic       start_request;
        logic       is_read;
        logic [7:0] register_address;
        logic [7:0] byte_count;
        logic [7:0] write_data;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        t_step      step;
        logic [3:0] bit_cnt;
        logic [1:0] quarter;
        logic [7:0] shift;
        logic [7:0] bytes_left;
        logic       read_mode;
        logic [7:0] held_reg;
    } t_state;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic [7:0] read_data;
        logic       read_valid;
        logic       read_last;
        logic       write_data_taken;
        logic       busy_res;
        logic       done_res;
        logic       ack_error;
    } t_result;

endpackage

// File: rtl/core/i2c_register_transfer_master.sv
`timescale 1ns / 1ps

// Register-addressed I2C master, advanced one quarter-bit tick per input item.
// Input channel (i_in_valid / o_in_stall): each item is one tick carrying the
// start request, transfer description, next write byte and the sampled SDA.
// Output channel (o_out_valid / i_out_stall): one result item per input item,
// carrying the SCL/SDA levels to drive, received bytes and status flags.
// The APB port holds the seven-bit device address (byte address 0, reset 104);
// write it only while no transfer is running.
// An accepted item is registered, then its tick is evaluated and the result
// is loaded into the output register when that register is empty or being taken.
// One item per cycle is accepted while the receiver does not stall; the
// sequencer state is updated as the result register loads.
// When the receiver stalls, hold the result register and the pending input
// item; the input side stalls only when both are full, so nothing is lost.
// Reset (synchronous, active low) empties both stages, returns the sequencer
// to idle and restores the device address. A missing ACK ends the transfer
// with done and ack_error and no stop; a read of zero bytes reads one.
module i2c_register_transfer_master (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [i2c_rtm_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [i2c_rtm_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [i2c_rtm_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                pready,
    // input items
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_start_request,
    input  logic                                i_is_read,
    input  logic [7:0]                          i_register_address,
    input  logic [7:0]                          i_byte_count,
    input  logic [7:0]                          i_write_data,
    input  logic                                i_sda_in,
    // result items
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_scl_out,
    output logic                                o_sda_out,
    output logic [7:0]                          o_read_data,
    output logic                                o_read_valid,
    output logic                                o_read_last,
    output logic                                o_write_data_taken,
    output logic                                o_busy_res,
    output logic                                o_done_res,
    output logic                                o_ack_error
);

    logic [6:0]             device_address;
    logic                   advance;

    logic                   r_in_valid;
    i2c_rtm_pkg::t_item     r_item;
    i2c_rtm_pkg::t_state    r_state;
    i2c_rtm_pkg::t_state    n_state;
    logic                   r_out_valid;
    i2c_rtm_pkg::t_result   r_res;
    i2c_rtm_pkg::t_result   n_res;

    i2c_rtm_cfg u_cfg (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_device_address (device_address)
    );

    i2c_rtm_step u_step (
        .i_state          (r_state),
        .i_item           (r_item),
        .i_device_address (device_address),
        .o_next           (n_state),
        .o_res            (n_res)
    );

    // Move the registered item into the result stage whenever that stage frees up
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_item.start_request    <= i_start_request;
            r_item.is_read          <= i_is_read;
            r_item.register_address <= i_register_address;
            r_item.byte_count       <= i_byte_count;
            r_item.write_data       <= i_write_data;
            r_item.sda_in           <= i_sda_in;
        end
    end

    // Sequencer state advances exactly once per item, as its result is stored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.step       <= i2c_rtm_pkg::ST_IDLE;
            r_state.bit_cnt    <= '0;
            r_state.quarter    <= i2c_rtm_pkg::Q0;
            r_state.shift      <= '0;
            r_state.bytes_left <= '0;
            r_state.read_mode  <= 1'b0;
            r_state.held_reg   <= '0;
        end else if (advance && r_in_valid) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_scl_out          = r_res.scl_out;
    assign o_sda_out          = r_res.sda_out;
    assign o_read_data        = r_res.read_data;
    assign o_read_valid       = r_res.read_valid;
    assign o_read_last        = r_res.read_last;
    assign o_write_data_taken = r_res.write_data_taken;
    assign o_busy_res         = r_res.busy_res;
    assign o_done_res         = r_res.done_res;
    assign o_ack_error        = r_res.ack_error;

endmodule

// File: rtl/core/i2c_rtm_cfg.sv
`timescale 1ns / 1ps

module i2c_rtm_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [i2c_rtm_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [i2c_rtm_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [i2c_rtm_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                pready,
    output logic [6:0]                          o_device_address
);

    logic [6:0] r_device_address;
    logic       sel_dev;

    assign pready  = 1'b1;
    assign sel_dev = (paddr[2] == i2c_rtm_pkg::REG_DEVICE_ADDR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_address <= i2c_rtm_pkg::DEVICE_ADDR_RESET;
        end else if (psel && penable && pwrite && pready && sel_dev) begin
            r_device_address <= pwdata[6:0];
        end
    end

    assign prdata = sel_dev ? {{(i2c_rtm_pkg::CFG_DATA_W-7){1'b0}}, r_device_address}
                            : '0;
    assign o_device_address = r_device_address;

endmodule

// File: rtl/core/i2c_rtm_step.sv
`timescale 1ns / 1ps

// One quarter-bit tick of the transfer sequencer: next state and line levels
module i2c_rtm_step (
    input  i2c_rtm_pkg::t_state  i_state,
    input  i2c_rtm_pkg::t_item   i_item,
    input  logic [6:0]           i_device_address,
    output i2c_rtm_pkg::t_state  o_next,
    output i2c_rtm_pkg::t_result o_res
);

    i2c_rtm_pkg::t_state cur;
    logic                bit_phase;   // still shifting data bits
    logic                last_byte;

    // Take a start request from idle; the same tick already drives Q0 of the start
    always_comb begin
        cur = i_state;
        if (i_state.step == i2c_rtm_pkg::ST_IDLE && i_item.start_request) begin
            cur.read_mode  = i_item.is_read;
            cur.held_reg   = i_item.register_address;
            cur.bytes_left = (i_item.is_read && i_item.byte_count == 8'd0)
                             ? 8'd1 : i_item.byte_count;
            cur.step       = i2c_rtm_pkg::ST_START;
            cur.bit_cnt    = '0;
            cur.quarter    = i2c_rtm_pkg::Q0;
        end
    end

    assign bit_phase = (cur.bit_cnt < i2c_rtm_pkg::BITS_PER_BYTE);
    assign last_byte = (cur.bytes_left <= 8'd1);

    // Next state
    always_comb begin
        o_next         = cur;
        o_next.quarter = (cur.step == i2c_rtm_pkg::ST_IDLE) ? i2c_rtm_pkg::Q0
                                                             : cur.quarter + 2'd1;
        case (cur.step)
            i2c_rtm_pkg::ST_IDLE: begin
            end
            i2c_rtm_pkg::ST_START, i2c_rtm_pkg::ST_RSTART: begin
                if (cur.quarter == i2c_rtm_pkg::Q3) begin
                    o_next.shift   = {i_device_address,
                                      (cur.step == i2c_rtm_pkg::ST_RSTART)};
                    o_next.bit_cnt = '0;
                    o_next.step    = (cur.step == i2c_rtm_pkg::ST_START)
                                     ? i2c_rtm_pkg::ST_ADDRW : i2c_rtm_pkg::ST_ADDRR;
                end
            end
            i2c_rtm_pkg::ST_ADDRW, i2c_rtm_pkg::ST_REG,
            i2c_rtm_pkg::ST_DATA, i2c_rtm_pkg::ST_ADDRR: begin
                if (bit_phase) begin
                    if (cur.quarter == i2c_rtm_pkg::Q3) begin
                        o_next.shift   = {cur.shift[6:0], 1'b0};
                        o_next.bit_cnt = cur.bit_cnt + 4'd1;
                    end
                end else if (cur.quarter == i2c_rtm_pkg::Q2 && i_item.sda_in) begin
                    // no ACK: drop the transfer, lines stay released
                    o_next.step    = i2c_rtm_pkg::ST_IDLE;
                    o_next.bit_cnt = '0;
                    o_next.quarter = i2c_rtm_pkg::Q0;
                end else if (cur.quarter == i2c_rtm_pkg::Q3) begin
                    o_next.bit_cnt = '0;
                    if (cur.step == i2c_rtm_pkg::ST_ADDRW) begin
                        o_next.shift = cur.held_reg;
                        o_next.step  = i2c_rtm_pkg::ST_REG;
                    end else if (cur.step == i2c_rtm_pkg::ST_ADDRR) begin
                        o_next.shift = '0;
                        o_next.step  = i2c_rtm_pkg::ST_RECV;
                    end else if (cur.step == i2c_rtm_pkg::ST_REG && cur.read_mode) begin
                        o_next.step = i2c_rtm_pkg::ST_RSTART;
                    end else if (cur.bytes_left != 8'd0) begin
                        o_next.shift      = i_item.write_data;
                        o_next.bytes_left = cur.bytes_left - 8'd1;
                        o_next.step       = i2c_rtm_pkg::ST_DATA;
                    end else begin
                        o_next.step = i2c_rtm_pkg::ST_STOP;
                    end
                end
            end
            i2c_rtm_pkg::ST_RECV: begin
                if (bit_phase) begin
                    if (cur.quarter == i2c_rtm_pkg::Q2) begin
                        o_next.shift = {cur.shift[6:0], i_item.sda_in};
                    end
                    if (cur.quarter == i2c_rtm_pkg::Q3) begin
                        o_next.bit_cnt = cur.bit_cnt + 4'd1;
                    end
                end else if (cur.quarter == i2c_rtm_pkg::Q3) begin
                    o_next.bit_cnt = '0;
                    if (last_byte) begin
                        o_next.step = i2c_rtm_pkg::ST_STOP;
                    end else begin
                        o_next.bytes_left = cur.bytes_left - 8'd1;
                        o_next.shift      = '0;
                    end
                end
            end
            i2c_rtm_pkg::ST_STOP: begin
                if (cur.quarter == i2c_rtm_pkg::Q3) begin
                    o_next.step = i2c_rtm_pkg::ST_IDLE;
                end
            end
            default: begin
                o_next.step    = i2c_rtm_pkg::ST_IDLE;
                o_next.bit_cnt = '0;
                o_next.quarter = i2c_rtm_pkg::Q0;
            end
        endcase
    end

    // Line levels and status
    always_comb begin
        o_res          = '0;
        o_res.scl_out  = 1'b1;
        o_res.sda_out  = 1'b1;
        o_res.busy_res = (cur.step != i2c_rtm_pkg::ST_IDLE);
        case (cur.step)
            i2c_rtm_pkg::ST_IDLE: begin
            end
            i2c_rtm_pkg::ST_START, i2c_rtm_pkg::ST_RSTART: begin
                if (cur.quarter == i2c_rtm_pkg::Q0) begin
                    o_res.scl_out = (cur.step == i2c_rtm_pkg::ST_START);
                end else begin
                    o_res.scl_out = (cur.quarter != i2c_rtm_pkg::Q3);
                end
                o_res.sda_out = (cur.quarter == i2c_rtm_pkg::Q0 ||
                                 cur.quarter == i2c_rtm_pkg::Q1);
            end
            i2c_rtm_pkg::ST_ADDRW, i2c_rtm_pkg::ST_REG,
            i2c_rtm_pkg::ST_DATA, i2c_rtm_pkg::ST_ADDRR: begin
                o_res.scl_out = (cur.quarter == i2c_rtm_pkg::Q1 ||
                                 cur.quarter == i2c_rtm_pkg::Q2);
                if (bit_phase) begin
                    o_res.sda_out = cur.shift[7];
                end else if (cur.quarter == i2c_rtm_pkg::Q2 && i_item.sda_in) begin
                    o_res.done_res  = 1'b1;
                    o_res.ack_error = 1'b1;
                end else if (cur.quarter == i2c_rtm_pkg::Q3) begin
                    o_res.sda_out = 1'b0;
                    if (cur.step != i2c_rtm_pkg::ST_ADDRW &&
                        cur.step != i2c_rtm_pkg::ST_ADDRR &&
                        !(cur.step == i2c_rtm_pkg::ST_REG && cur.read_mode) &&
                        cur.bytes_left != 8'd0) begin
                        o_res.write_data_taken = 1'b1;
                    end
                end
            end
            i2c_rtm_pkg::ST_RECV: begin
                o_res.scl_out = (cur.quarter == i2c_rtm_pkg::Q1 ||
                                 cur.quarter == i2c_rtm_pkg::Q2);
                if (bit_phase) begin
                    if (cur.quarter == i2c_rtm_pkg::Q3 &&
                        cur.bit_cnt == i2c_rtm_pkg::LAST_BIT) begin
                        o_res.read_valid = 1'b1;
                        o_res.read_data  = cur.shift;
                        o_res.read_last  = last_byte;
                    end
                end else begin
                    // ACK every byte but the last, NACK the last
                    o_res.sda_out = last_byte;
                end
            end
            i2c_rtm_pkg::ST_STOP: begin
                o_res.scl_out  = (cur.quarter != i2c_rtm_pkg::Q0);
                o_res.sda_out  = (cur.quarter == i2c_rtm_pkg::Q2 ||
                                  cur.quarter == i2c_rtm_pkg::Q3);
                o_res.done_res = (cur.quarter == i2c_rtm_pkg::Q3);
            end
            default: begin
                o_res.busy_res = 1'b0;
            end
        endcase
    end

endmodule
